// ===== hw/rtl/aes128_ctr_siv_encrypt_top_defines.svh =====
// assertion macros for the counter-mode encryption block
`ifndef AES128_CTR_SIV_ENCRYPT_TOP_DEFINES_SVH
`define AES128_CTR_SIV_ENCRYPT_TOP_DEFINES_SVH
`define ACS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ACS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hw/rtl/acs_pkg.sv =====
// shared types, constants and functions of the counter-mode encryption block
package acs_pkg;
  localparam int unsigned ROUNDS_DEF = 10;
  localparam logic [31:0] TOP_BIT = 32'h8000_0000;
  localparam logic [4:0] FULL_BYTES = 5'd16;

  typedef enum logic [1:0] {
    FUNC_KEY   = 2'd0,
    FUNC_START = 2'd1,
    FUNC_DATA  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_ROUND = 2'd1,
    ST_OUT   = 2'd2
  } state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  key_index;
    logic [63:0] data_lo;
    logic [63:0] data_hi;
    logic [4:0]  byte_count;
  } in_word_t;

  typedef struct packed {
    logic [63:0] out_lo;
    logic [63:0] out_hi;
    logic [4:0]  out_bytes;
  } out_word_t;

  typedef struct packed {
    logic first;
    logic last;
  } round_ctl_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction
endpackage

// ===== hw/rtl/aes128_ctr_siv_encrypt_top.sv =====
// top level of the aes-128 counter-mode encryption block
// usage:
//   in channel (in_valid/in_ready/in_data) takes key, start and data words.
//   a key word writes one round key into the key ram; a start word loads
//   the counter from the tag with bit 127 set. neither gives a result.
//   a data word encrypts the counter, xors the plaintext and produces one
//   out word (out_valid/out_ready/out_data) with bytes past the count zero.
// processing:
//   a data word runs through the key add and ROUNDS rounds, one per cycle
//   through the single shared round unit, with round key 0 read in the
//   accepting cycle, and then shows out_valid. the in channel is not ready
//   while a data word is in flight.
// reset:
//   rst clears the counter and the control state; round keys are undefined
//   until written.
// stall:
//   the result is held in the output register until out_ready; the next
//   input word is accepted in the same cycle the result is taken.
module aes128_ctr_siv_encrypt_top #(
  parameter int unsigned ROUNDS = acs_pkg::ROUNDS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  acs_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output acs_pkg::out_word_t  out_data
);
  import acs_pkg::*;

  localparam int unsigned KEYS = ROUNDS + 1;
  localparam int unsigned KW = $clog2(KEYS);
  localparam int unsigned RW = $clog2(KEYS + 1);

  state_t state, state_next;
  logic [RW-1:0] rnd;
  logic [127:0] ctr;
  logic [127:0] st;
  logic [127:0] pt;
  logic [4:0]   cnt;
  logic [127:0] rk;
  logic [127:0] rnd_out;
  logic [KW-1:0] raddr;
  logic         acc;
  logic         key_we;
  round_ctl_t   ctl;
  logic [127:0] ct;

  assign acc = in_valid && in_ready;
  assign key_we = acc && (in_data.func == FUNC_KEY) && (in_data.key_index <= 4'(ROUNDS));

  always_comb begin
    if (acc) begin
      raddr = '0;
    end else if (rnd < RW'(ROUNDS)) begin
      raddr = KW'(rnd + RW'(1));
    end else begin
      raddr = KW'(ROUNDS);
    end
  end

  acs_ram #(.WIDTH(128), .DEPTH(KEYS)) u_keys (
    .clk   (clk),
    .we    (key_we),
    .waddr (in_data.key_index[KW-1:0]),
    .wdata ({in_data.data_hi, in_data.data_lo}),
    .raddr (raddr),
    .rdata (rk)
  );

  assign ctl.first = (rnd == '0);
  assign ctl.last  = (rnd == RW'(ROUNDS));

  acs_round u_round (
    .first     (ctl.first),
    .last      (ctl.last),
    .state_in  (st),
    .round_key (rk),
    .state_out (rnd_out)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc && in_data.func == FUNC_DATA) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (ctl.last) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          state_next = (acc && in_data.func == FUNC_DATA) ? ST_ROUND : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE:  in_ready = 1'b1;
      ST_ROUND: in_ready = 1'b0;
      ST_OUT: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
      end
      default: in_ready = 1'b0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      ct[8*i +: 8] = (5'(i) < cnt) ? (rnd_out[8*i +: 8] ^ pt[8*i +: 8]) : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ctr   <= '0;
      rnd   <= '0;
    end else begin
      state <= state_next;
      if (acc && in_data.func == FUNC_START) begin
        ctr <= {in_data.data_hi[63:32] | TOP_BIT, in_data.data_hi[31:0], in_data.data_lo};
      end
      if (acc && in_data.func == FUNC_DATA) begin
        rnd <= '0;
        st  <= ctr;
        pt  <= {in_data.data_hi, in_data.data_lo};
        cnt <= (in_data.byte_count > FULL_BYTES) ? FULL_BYTES : in_data.byte_count;
      end else if (state == ST_ROUND) begin
        rnd <= rnd + RW'(1);
        st  <= rnd_out;
        if (ctl.last) begin
          out_data.out_lo    <= ct[63:0];
          out_data.out_hi    <= ct[127:64];
          out_data.out_bytes <= cnt;
          ctr[31:0]          <= ctr[31:0] + 32'd1;
        end
      end
    end
  end
endmodule

// ===== hw/rtl/acs_ram.sv =====
// generic single-port-write ram with registered read
module acs_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/acs_round.sv =====
// shared aes round unit: key add, full round or final round
module acs_round (
  input  logic                   first,
  input  logic                   last,
  input  logic [127:0]           state_in,
  input  logic [127:0]           round_key,
  output logic [127:0]           state_out
);
  import acs_pkg::*;

  logic [7:0] s [16];
  logic [7:0] t [16];
  logic [7:0] m [16];

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state_in[8*i +: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r + 4*c] = sbox(s[r + 4*((c + r) % 4)]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] all;
      all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      m[4*c]   = t[4*c]   ^ all ^ xtime(t[4*c]   ^ t[4*c+1]);
      m[4*c+1] = t[4*c+1] ^ all ^ xtime(t[4*c+1] ^ t[4*c+2]);
      m[4*c+2] = t[4*c+2] ^ all ^ xtime(t[4*c+2] ^ t[4*c+3]);
      m[4*c+3] = t[4*c+3] ^ all ^ xtime(t[4*c+3] ^ t[4*c]);
    end
    for (int i = 0; i < 16; i++) begin
      if (first) begin
        state_out[8*i +: 8] = s[i] ^ round_key[8*i +: 8];
      end else if (last) begin
        state_out[8*i +: 8] = t[i] ^ round_key[8*i +: 8];
      end else begin
        state_out[8*i +: 8] = m[i] ^ round_key[8*i +: 8];
      end
    end
  end
endmodule

// ===== hw/rtl/acs_checker.sv =====
// port-level checker for the encryption block, bound to the top level
`include "aes128_ctr_siv_encrypt_top_defines.svh"
module acs_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input acs_pkg::in_word_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input acs_pkg::out_word_t out_data
);
  import acs_pkg::*;

  `ACS_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  `ACS_ASSERT_IMP(a_bytes_range, clk, rst, out_valid, out_data.out_bytes <= FULL_BYTES)
  `ACS_ASSERT_NXT(a_busy_after_data, clk, rst, in_valid && in_ready && in_data.func == FUNC_DATA, !in_ready && !out_valid)
  `ACS_ASSERT_IMP(a_ready_when_wait, clk, rst, out_valid && !out_ready, !in_ready)
endmodule

bind aes128_ctr_siv_encrypt_top acs_checker u_acs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/sv/tb_top.sv =====
// self-checking testbench of the aes-128 counter-mode encryption block
`timescale 1ns / 100ps
module tb_top;
  import acs_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;

  aes128_ctr_siv_encrypt_top DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [7:0]   sb [256];
  logic [127:0] rkey [11];
  logic [127:0] ctr_blk;
  in_word_t     pend_words [$];
  out_word_t    cipher_q [$];
  int errors = 0;
  int n_data = 0;
  int n_words = 0;
  bit stim_done = 0;
  bit in_taken = 0;

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] k,
                                              input bit mix);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] r;
    for (int c = 0; c < 4; c++)
      for (int w = 0; w < 4; w++)
        t[w + 4 * c] = sb[s[8 * (w + 4 * ((c + w) & 3)) +: 8]];
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[4 * c] = a0 ^ al ^ xt(a0 ^ a1);
        t[4 * c + 1] = a1 ^ al ^ xt(a1 ^ a2);
        t[4 * c + 2] = a2 ^ al ^ xt(a2 ^ a3);
        t[4 * c + 3] = a3 ^ al ^ xt(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) r[8 * i +: 8] = t[i];
    return r ^ k;
  endfunction

  task automatic predict_cipher(input in_word_t w);
    logic [127:0] s, p;
    logic [4:0] cnt;
    out_word_t o;
    case (func_t'(w.func))
      FUNC_KEY: if (w.key_index <= 4'd10) rkey[w.key_index] = {w.data_hi, w.data_lo};
      FUNC_START: ctr_blk = {w.data_hi[63:32] | TOP_BIT, w.data_hi[31:0], w.data_lo};
      FUNC_DATA: begin
        cnt = (w.byte_count > FULL_BYTES) ? FULL_BYTES : w.byte_count;
        s = ctr_blk ^ rkey[0];
        for (int k = 1; k < 10; k++) s = aes_round(s, rkey[k], 1);
        s = aes_round(s, rkey[10], 0);
        p = s ^ {w.data_hi, w.data_lo};
        for (int i = 0; i < 16; i++) if (i >= cnt) p[8 * i +: 8] = 8'h00;
        o.out_lo = p[63:0];
        o.out_hi = p[127:64];
        o.out_bytes = cnt;
        cipher_q.push_back(o);
        ctr_blk[31:0] = ctr_blk[31:0] + 32'd1;
        n_data++;
      end
      default: ;
    endcase
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // driver
  int in_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        n_words++;
        in_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 18) : 0;
      end
      if (!in_valid || in_taken) begin
        if (in_gap > 0 || pend_words.size() == 0) begin
          if (in_gap > 0) in_gap--;
          in_valid <= 1'b0;
        end else begin
          in_data <= pend_words.pop_front();
          in_valid <= 1'b1;
        end
      end
      in_taken = 1'b0;
    end
  end

  // predict on acceptance
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      predict_cipher(in_data);
      in_taken = 1'b1;
    end
  end

  // monitor
  int out_gap = 0;
  always @(posedge clk) begin
    out_word_t e;
    if (!rst && out_valid && out_ready) begin
      if (cipher_q.size() == 0) begin
        report("unexpected word", out_data.out_lo, 64'd0);
      end else begin
        e = cipher_q.pop_front();
        if (out_data.out_lo !== e.out_lo) report("out_lo", out_data.out_lo, e.out_lo);
        if (out_data.out_hi !== e.out_hi) report("out_hi", out_data.out_hi, e.out_hi);
        if (out_data.out_bytes !== e.out_bytes)
          report("out_bytes", out_data.out_bytes, e.out_bytes);
      end
    end
  end

  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else if (out_ready && out_valid) begin
      out_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 18) : 0;
      out_ready <= (out_gap == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic in_word_t mk(input func_t f, input logic [3:0] ki,
                                  input logic [63:0] lo, input logic [63:0] hi,
                                  input logic [4:0] bc);
    in_word_t w;
    w.func = f; w.key_index = ki; w.data_lo = lo; w.data_hi = hi; w.byte_count = bc;
    return w;
  endfunction

  function automatic logic [63:0] r64();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_keys();
    for (int k = 0; k <= 10; k++)
      pend_words.push_back(mk(FUNC_KEY, 4'(k), r64(), r64(), 5'($urandom)));
  endtask

  initial begin
    int n;
    for (int i = 0; i < 256; i++) sb[i] = sbox(8'(i));
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // directed: keys, ignored indexes, tag extremes, count corners, unused func
    queue_keys();
    pend_words.push_back(mk(FUNC_KEY, 4'd11, r64(), r64(), 5'd0));
    pend_words.push_back(mk(FUNC_KEY, 4'd15, '1, '1, '1));
    pend_words.push_back(mk(FUNC_DATA, 4'd0, '0, '0, 5'd16));
    pend_words.push_back(mk(FUNC_START, 4'd0, {32'h0, 32'hffff_fffe}, '1, 5'd0));
    pend_words.push_back(mk(FUNC_DATA, 4'd15, '1, '1, 5'd16));
    pend_words.push_back(mk(FUNC_DATA, 4'd0, '1, '1, 5'd1));
    pend_words.push_back(mk(FUNC_DATA, 4'd0, '1, '1, 5'd0));
    pend_words.push_back(mk(FUNC_DATA, 4'd0, r64(), r64(), 5'd31));
    pend_words.push_back(mk(FUNC_DATA, 4'd0, r64(), r64(), 5'd17));
    pend_words.push_back(mk(FUNC_NONE, 4'd3, r64(), r64(), 5'd5));
    pend_words.push_back(mk(FUNC_START, 4'd0, '0, '0, 5'd16));
    pend_words.push_back(mk(FUNC_DATA, 4'd0, r64(), r64(), 5'd15));
    // random: mostly messages of random length, some key reloads and noise
    n = 0;
    while (n < 1050) begin
      case ($urandom_range(0, 9))
        0: begin queue_keys(); n += 11; end
        1: begin
          pend_words.push_back(mk(func_t'($urandom_range(0, 1) ? FUNC_NONE : FUNC_KEY),
                                  4'($urandom_range(11, 15)), r64(), r64(), 5'($urandom)));
          n++;
        end
        default: begin
          pend_words.push_back(mk(FUNC_START, 4'($urandom), r64(), r64(), 5'($urandom)));
          n++;
          repeat ($urandom_range(1, 8)) begin
            pend_words.push_back(mk(FUNC_DATA, 4'($urandom), r64(), r64(),
                                    $urandom_range(0, 2) == 0 ? 5'($urandom) : 5'd16));
            n++;
          end
        end
      endcase
    end
    wait (pend_words.size() == 0 && !in_valid);
    wait (cipher_q.size() == 0);
    repeat (40) @(posedge clk);
    $display("ran %0d input words, %0d encrypted blocks with key reloads and tag restarts",
             n_words, n_data);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end
endmodule
